// File: rtl/core/rusc_pkg.sv
// Shared types and constants for the rANS uniform stack coder.
// No dependencies; imported by rusc_div and rans_uniform_stack_coder.
`timescale 1ns / 1ps
`default_nettype none

package rusc_pkg;

  localparam int unsigned StackWords = 4096;
  localparam int unsigned AddrW      = $clog2(StackWords);
  localparam int unsigned CountW     = 13;
  localparam int unsigned HeadW      = 64;
  localparam int unsigned WordW      = 32;
  localparam int unsigned PrecW      = 7;
  localparam int unsigned DivStepW   = $clog2(HeadW);

  localparam logic [HeadW-1:0]  LowBound   = 64'h0000_0000_8000_0000;
  localparam logic [CountW-1:0] StackFull  = CountW'(StackWords);
  localparam logic [PrecW-1:0]  PrecReset  = 7'd32;

  typedef enum logic [1:0] {
    OP_PUSH_UNI = 2'd0,
    OP_POP_UNI  = 2'd1,
    OP_PUSH_SYM = 2'd2,
    OP_POP_SYM  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_VALUE = 2'd3
  } status_e;

endpackage

`default_nettype wire

// File: rtl/core/rusc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rusc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/rusc_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Depends on rusc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module rusc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rusc_pkg::HeadW-1:0]   dividend_i,
  input  wire logic [rusc_pkg::WordW-1:0]   divisor_i,
  output logic                              done_o,
  output logic      [rusc_pkg::HeadW-1:0]   quot_o,
  output logic      [rusc_pkg::WordW-1:0]   rem_o
);
  import rusc_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [DivStepW-1:0] cnt_q;
  logic [HeadW-1:0]    dvd_q;
  logic [WordW-1:0]    rem_q;
  logic [WordW-1:0]    dvs_q;
  logic [WordW:0]      trial;
  logic                fits;

  assign trial = {rem_q, dvd_q[HeadW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Pulse done for one cycle after the last quotient bit
      done_q <= !start_i && busy_q && (cnt_q == {DivStepW{1'b1}});
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {DivStepW{1'b1}}) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift quotient bits into the dividend register as it drains
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[HeadW-2:0], fits};
      rem_q <= fits ? WordW'(trial - {1'b0, dvs_q}) : trial[WordW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/rans_uniform_stack_coder.sv
// Top level of the rANS stack coder: sequencer, head datapath, word stack RAM.
// Depends on rusc_pkg, rusc_ram and rusc_div.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   in       | in_valid_i/in_ready_o | opcode_i, value_i, modulus_i
//   out      | out_valid_o/out_ready_i| decoded_o, head_now_o, stack_count_o,
//            |                       | status_o
//   cfg      | cfg_valid_i/cfg_ready_o| cfg_symbol_precision_i
//
// One item at a time. Uniform push, with or without a word pulled back, runs
// the 64-step divider that forms 2^31 / modulus for the spill threshold.
// Uniform pop, also with a pull, makes two divider passes (threshold, then
// head / modulus). Symbol pop waits in S_PULL_WAIT for each word read back
// from the stack RAM (registered read). A finished result sits in the output
// register, and the next item is taken while it waits; the sequencer only
// holds in its final state while that register is still full.
// Reset: head 2^31, empty stack, precision 32. The stack RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rans_uniform_stack_coder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [rusc_pkg::HeadW-1:0]    value_i,
  input  wire logic [rusc_pkg::WordW-1:0]    modulus_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rusc_pkg::HeadW-1:0]    decoded_o,
  output logic      [rusc_pkg::HeadW-1:0]    head_now_o,
  output logic      [rusc_pkg::CountW-1:0]   stack_count_o,
  output logic      [1:0]                    status_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rusc_pkg::PrecW-1:0]    cfg_symbol_precision_i
);
  import rusc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DQ_GO,
    S_DQ_WAIT,
    S_MUL_T,
    S_SPILL_CHK,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD,
    S_DH_GO,
    S_DH_WAIT,
    S_PULL_REQ,
    S_PULL_WAIT,
    S_SYM_PUSH,
    S_SYM_POP,
    S_FIN
  } state_e;

  state_e state_q;

  // Committed architectural state
  logic [HeadW-1:0]  head_q;
  logic [CountW-1:0] sp_q;
  logic [PrecW-1:0]  prec_q;

  // Working copies for the item in flight
  op_e               op_q;
  logic [HeadW-1:0]  val_q;
  logic [WordW-1:0]  n_q;
  logic [HeadW-1:0]  h_q;
  logic [CountW-1:0] wsp_q;
  logic [HeadW-1:0]  dec_q;
  status_e           err_q;
  logic [1:0]        k_q;
  logic [WordW-1:0]  thr_q;
  logic [HeadW-1:0]  prod_q;
  logic [HeadW-1:0]  plo_q;

  // Output register
  logic              out_valid_q;
  logic [HeadW-1:0]  out_dec_q;
  logic [HeadW-1:0]  out_head_q;
  logic [CountW-1:0] out_cnt_q;
  status_e           out_st_q;

  // Divider
  logic              div_start;
  logic [HeadW-1:0]  div_dvd;
  logic              div_done;
  logic [HeadW-1:0]  div_quot;
  logic [WordW-1:0]  div_rem;

  // Stack RAM
  logic              ram_we;
  logic [AddrW-1:0]  ram_raddr;
  logic [WordW-1:0]  ram_rdata;
  logic [CountW-1:0] wsp_dec;

  // Datapath
  logic [WordW-1:0]  mul_a;
  logic [HeadW-1:0]  mul_p;
  logic [HeadW-1:0]  add_sum;
  logic [WordW-1:0]  spill_thr;
  logic              spill_uni;
  logic              stack_full;
  logic [1:0]        slice_idx;
  logic [4:0]        slice_p;
  logic [16:0]       mask_full;
  logic [15:0]       slice_mask;
  logic [15:0]       slice_val;
  logic              sym_spill;
  logic [HeadW-1:0]  sym_base;
  logic [HeadW-1:0]  sym_push_h;
  logic [HeadW-1:0]  sym_q;
  logic              sym_pull;
  logic              fin_go;
  logic              accept;

  // Precision of one 16-bit slice: configured precision less the slice
  // offset, clipped to 0..16.
  function automatic logic [4:0] slice_prec(input logic [PrecW-1:0] prec,
                                            input logic [1:0] idx);
    logic [PrecW-1:0] lower;
    logic [PrecW-1:0] diff;
    lower = {1'b0, idx, 4'b0000};
    diff  = prec - lower;
    if (prec <= lower) begin
      slice_prec = 5'd0;
    end else if (diff > 7'd16) begin
      slice_prec = 5'd16;
    end else begin
      slice_prec = diff[4:0];
    end
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign stack_full  = (wsp_q >= StackFull);
  assign wsp_dec     = wsp_q - 1'b1;

  // Shared 32x32 multiplier, one operand picked per state
  always_comb begin
    case (state_q)
      S_MUL_T:  mul_a = thr_q;
      S_MUL_LO: mul_a = h_q[WordW-1:0];
      default:  mul_a = h_q[HeadW-1:WordW];
    endcase
  end
  assign mul_p   = mul_a * n_q;
  assign add_sum = plo_q + {prod_q[WordW-1:0], {WordW{1'b0}}} + val_q;

  // Uniform spill threshold: quotient for push, modulus times quotient for pop
  assign spill_thr = (op_q == OP_POP_UNI) ? prod_q[WordW-1:0] : thr_q;
  assign spill_uni = h_q[HeadW-1:WordW] >= spill_thr;

  // Symbol slices: push walks low to high, pop walks high to low
  assign slice_idx  = (op_q == OP_POP_SYM) ? ~k_q : k_q;
  assign slice_p    = slice_prec(prec_q, slice_idx);
  assign mask_full  = (17'd1 << slice_p) - 17'd1;
  assign slice_mask = mask_full[15:0];
  assign slice_val  = val_q[{slice_idx, 4'b0000} +: 16] & slice_mask;
  assign sym_spill  = h_q[HeadW-1:WordW] >= (32'h8000_0000 >> slice_p);
  assign sym_base   = sym_spill ? {{WordW{1'b0}}, h_q[HeadW-1:WordW]} : h_q;
  assign sym_push_h = (sym_base << slice_p) + {48'd0, slice_val};
  assign sym_q      = h_q >> slice_p;
  assign sym_pull   = sym_q < LowBound;

  assign div_start = (state_q == S_DQ_GO) || (state_q == S_DH_GO);
  assign div_dvd   = (state_q == S_DH_GO) ? h_q : LowBound;

  assign ram_we = (!stack_full) &&
                  (((state_q == S_SPILL_CHK) && spill_uni) ||
                   ((state_q == S_SYM_PUSH) && sym_spill && (err_q == ST_OK)));
  assign ram_raddr = wsp_dec[AddrW-1:0];

  rusc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rusc_ram #(
    .Width (WordW),
    .Depth (StackWords)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wsp_q[AddrW-1:0]),
    .wdata_i (h_q[WordW-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= LowBound;
      sp_q        <= '0;
      prec_q      <= PrecReset;
      out_valid_q <= 1'b0;
      err_q       <= ST_OK;
      k_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        prec_q <= cfg_symbol_precision_i;
      end
      // Drop the result once taken, unless a new one lands this cycle
      if (out_valid_q && out_ready_i && !fin_go) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q  <= op_e'(opcode_i);
            val_q <= value_i;
            n_q   <= modulus_i;
            h_q   <= head_q;
            wsp_q <= sp_q;
            dec_q <= '0;
            err_q <= ST_OK;
            k_q   <= '0;
            unique case (op_e'(opcode_i))
              OP_PUSH_UNI: begin
                if ((modulus_i == '0) || (value_i >= {32'd0, modulus_i})) begin
                  err_q   <= ST_BAD_VALUE;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_DQ_GO;
                end
              end
              OP_POP_UNI: begin
                if (modulus_i == '0) begin
                  err_q   <= ST_BAD_VALUE;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_DQ_GO;
                end
              end
              OP_PUSH_SYM: state_q <= S_SYM_PUSH;
              default:     state_q <= S_SYM_POP;
            endcase
          end
        end

        S_DQ_GO: state_q <= S_DQ_WAIT;

        S_DQ_WAIT: begin
          if (div_done) begin
            thr_q   <= div_quot[WordW-1:0];
            state_q <= (op_q == OP_POP_UNI) ? S_MUL_T : S_SPILL_CHK;
          end
        end

        S_MUL_T: begin
          prod_q  <= mul_p;
          state_q <= S_SPILL_CHK;
        end

        S_SPILL_CHK: begin
          if (spill_uni && stack_full) begin
            err_q   <= ST_OVERFLOW;
            state_q <= S_FIN;
          end else begin
            if (spill_uni) begin
              wsp_q <= wsp_q + 1'b1;
              h_q   <= {{WordW{1'b0}}, h_q[HeadW-1:WordW]};
            end
            state_q <= (op_q == OP_POP_UNI) ? S_DH_GO : S_MUL_LO;
          end
        end

        S_MUL_LO: begin
          prod_q  <= mul_p;
          state_q <= S_MUL_HI;
        end

        S_MUL_HI: begin
          plo_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= S_ADD;
        end

        S_ADD: begin
          h_q     <= add_sum;
          state_q <= (add_sum < LowBound) ? S_PULL_REQ : S_FIN;
        end

        S_DH_GO: state_q <= S_DH_WAIT;

        S_DH_WAIT: begin
          if (div_done) begin
            dec_q   <= {{WordW{1'b0}}, div_rem};
            h_q     <= div_quot;
            state_q <= (h_q < LowBound) ? S_PULL_REQ : S_FIN;
          end
        end

        S_PULL_REQ: begin
          if (wsp_q == '0) begin
            err_q   <= ST_UNDERFLOW;
            state_q <= S_FIN;
          end else begin
            wsp_q   <= wsp_dec;
            state_q <= S_PULL_WAIT;
          end
        end

        S_PULL_WAIT: begin
          h_q <= {h_q[WordW-1:0], ram_rdata};
          if (op_q == OP_POP_SYM && k_q != 2'd3) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_SYM_POP;
          end else begin
            state_q <= S_FIN;
          end
        end

        S_SYM_PUSH: begin
          if (sym_spill && stack_full) begin
            err_q   <= ST_OVERFLOW;
            state_q <= S_FIN;
          end else begin
            if (sym_spill) begin
              wsp_q <= wsp_q + 1'b1;
            end
            h_q <= sym_push_h;
            k_q <= k_q + 1'b1;
            if (k_q == 2'd3) begin
              state_q <= S_FIN;
            end
          end
        end

        S_SYM_POP: begin
          dec_q <= {dec_q[47:0], h_q[15:0] & slice_mask};
          h_q   <= sym_q;
          if (sym_pull) begin
            if (wsp_q == '0) begin
              err_q   <= ST_UNDERFLOW;
              state_q <= S_FIN;
            end else begin
              wsp_q   <= wsp_dec;
              state_q <= S_PULL_WAIT;
            end
          end else if (k_q == 2'd3) begin
            state_q <= S_FIN;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        S_FIN: begin
          // Commit only a clean item; an error leaves head and stack as before
          if (fin_go) begin
            out_valid_q <= 1'b1;
            out_st_q    <= err_q;
            if (err_q == ST_OK) begin
              head_q     <= h_q;
              sp_q       <= wsp_q;
              out_dec_q  <= dec_q;
              out_head_q <= h_q;
              out_cnt_q  <= wsp_q;
            end else begin
              out_dec_q  <= '0;
              out_head_q <= head_q;
              out_cnt_q  <= sp_q;
            end
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign decoded_o     = out_dec_q;
  assign head_now_o    = out_head_q;
  assign stack_count_o = out_cnt_q;
  assign status_o      = out_st_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= StackFull)
    else $error("stack pointer beyond stack depth");

  a_err_dec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (decoded_o == '0))
    else $error("failed item reports a decoded value");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (wsp_q < StackFull))
    else $error("stack write past the top");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && (err_q != ST_OK)) |=> ($stable(head_q) && $stable(sp_q)))
    else $error("failed item changed coder state");

endmodule

`default_nettype wire
